FILE: hw/rtl/tgfrs_pkg.sv
// Shared constants, flag maps and memory port type of the tile grid block.
package tgfrs_pkg;

  // Grid geometry: cell address is {row, column}
  localparam int MAX_SIDE  = 64;
  localparam int SIDE_BITS = $clog2(MAX_SIDE);
  localparam int DIM_BITS  = SIDE_BITS + 1;
  localparam int ADDR_BITS = 2 * SIDE_BITS;
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;

  // Cell word: tile in the upper bits, orientation flags in the low three
  localparam int TILE_BITS = 16;
  localparam int FLAG_BITS = 3;
  localparam int CELL_BITS = TILE_BITS + FLAG_BITS;

  // Request types
  localparam logic [1:0] REQ_NEW   = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_XFORM = 2'd3;

  // Transform kinds
  localparam logic [2:0] XF_FLIP_H = 3'd0;
  localparam logic [2:0] XF_FLIP_V = 3'd1;
  localparam logic [2:0] XF_ROT_R  = 3'd2;
  localparam logic [2:0] XF_ROT_L  = 3'd3;
  localparam logic [2:0] XF_SHIFT  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_POS  = 2'd1;
  localparam logic [1:0] ST_SIZE = 2'd2;

  // Orientation flag bits
  localparam logic [FLAG_BITS-1:0] FLAG_H = 3'b100;
  localparam logic [FLAG_BITS-1:0] FLAG_V = 3'b010;

  // Flag remap tables for quarter turns
  localparam logic [FLAG_BITS-1:0] ROT_RIGHT_MAP [8] = '{
    3'd5, 3'd4, 3'd1, 3'd0, 3'd7, 3'd6, 3'd3, 3'd2
  };
  localparam logic [FLAG_BITS-1:0] ROT_LEFT_MAP [8] = '{
    3'd3, 3'd2, 3'd7, 3'd6, 3'd1, 3'd0, 3'd5, 3'd4
  };

  // One write port and one read port onto the two cell banks
  typedef struct packed {
    logic                 we;
    logic                 wbank;
    logic [ADDR_BITS-1:0] waddr;
    logic [CELL_BITS-1:0] wdata;
    logic                 re;
    logic                 rbank;
    logic [ADDR_BITS-1:0] raddr;
  } tgfrs_mem_req_t;

endpackage

FILE: hw/rtl/tgfrs_cell_store.sv
// Two cell banks with one write and one registered read per cycle.
module tgfrs_cell_store import tgfrs_pkg::*; (
  input  logic                 clk_i,
  input  tgfrs_mem_req_t       req_i,
  output logic [CELL_BITS-1:0] rdata_o
);

  logic [CELL_BITS-1:0] bank_a_q [DEPTH];
  logic [CELL_BITS-1:0] bank_b_q [DEPTH];
  logic [CELL_BITS-1:0] rd_a_q;
  logic [CELL_BITS-1:0] rd_b_q;
  logic                 rbank_q;

  // Bank a: write, then registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we && !req_i.wbank) begin
      bank_a_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_a_q <= bank_a_q[req_i.raddr];
    end
  end

  // Bank b: write, then registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we && req_i.wbank) begin
      bank_b_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_b_q <= bank_b_q[req_i.raddr];
    end
  end

  // Remember which bank the read came from
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rbank_q <= req_i.rbank;
    end
  end

  assign rdata_o = rbank_q ? rd_b_q : rd_a_q;

endmodule

FILE: hw/rtl/tile_grid_flip_rotate_shift.sv
// Tile grid with cell write/read, new cleared grid, and flip/rotate/shift transforms.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_ready_o | req_type .. new_height, one per beat
//  out     | output    | out_valid_o/out_ready_i | cell_tile .. status, one per beat
//
// One request at a time. A read returns the cell from the registered bank read.
// New grid: the sweep clears one cell per cycle.
// Transform: the setup state reduces the shift origin, then one cell per cycle is read from
// the active bank and written into the other, then a bank swap (an empty grid skips the scan).
// Reset clears control only; the grid starts at 0 by 0, so no clearing pass runs.
// A stalled result sits in the output register while the next beat is accepted.
module tile_grid_flip_rotate_shift import tgfrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [5:0]           pos_x_i,
  input  logic [5:0]           pos_y_i,
  input  logic [TILE_BITS-1:0] tile_id_i,
  input  logic [2:0]           flip_bits_i,
  input  logic [2:0]           transform_kind_i,
  input  logic [7:0]           shift_x_i,
  input  logic [7:0]           shift_y_i,
  input  logic                 wrap_x_i,
  input  logic                 wrap_y_i,
  input  logic [6:0]           new_width_i,
  input  logic [6:0]           new_height_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TILE_BITS-1:0] cell_tile_o,
  output logic [2:0]           cell_flips_o,
  output logic [6:0]           grid_width_o,
  output logic [6:0]           grid_height_o,
  output logic [1:0]           status_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_RDATA = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int REM_BITS = 2 * DIM_BITS;

  // Control state
  logic [2:0]          state_q, state_d;
  logic                active_q, active_d;
  logic [DIM_BITS-1:0] w_q, w_d, h_q, h_d;
  logic                wr_pend_q, wr_pend_d;
  logic                out_valid_q, out_valid_d;

  // Working registers
  logic [SIDE_BITS-1:0] x_q, x_d, y_q, y_d;
  logic [2:0]           kind_q, kind_d;
  logic [7:0]           sx_q, sx_d, sy_q, sy_d;
  logic                 wrapx_q, wrapx_d, wrapy_q, wrapy_d;
  logic [REM_BITS-1:0]  rx_q, rx_d, ry_q, ry_d;
  logic [2:0]           k_q, k_d;
  logic [SIDE_BITS-1:0] ox0_q, ox0_d;
  logic [SIDE_BITS-1:0] oxw_q, oxw_d, oyw_q, oyw_d;
  logic [ADDR_BITS-1:0] wr_addr_q, wr_addr_d;
  logic                 wr_zero_q, wr_zero_d;
  logic [TILE_BITS-1:0] res_tile_q, res_tile_d;
  logic [2:0]           res_flips_q, res_flips_d;
  logic [1:0]           res_status_q, res_status_d;

  // Output register
  logic [TILE_BITS-1:0] out_tile_q;
  logic [2:0]           out_flips_q;
  logic [6:0]           out_w_q, out_h_q;
  logic [1:0]           out_status_q;
  logic                 out_load;

  // Memory port
  tgfrs_mem_req_t       mem_req;
  logic [CELL_BITS-1:0] mem_rdata;

  // Scan helpers
  logic                 in_fire;
  logic                 pos_in;
  logic [DIM_BITS-1:0]  wm1, hm1, mir_x, mir_y;
  logic                 row_end, col_end, last_row;
  logic signed [8:0]    ox_raw, oy_raw;
  logic                 ok_x, ok_y;
  logic [SIDE_BITS-1:0] src_x, src_y;
  logic                 src_ok;
  logic [ADDR_BITS-1:0] dst_addr;
  logic [REM_BITS-1:0]  dx, dy, rx_step, ry_step;
  logic [FLAG_BITS-1:0] rd_flags, new_flags;
  logic [CELL_BITS-1:0] scan_wdata;

  tgfrs_cell_store u_store (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign pos_in     = ({1'b0, pos_x_i} < w_q) && ({1'b0, pos_y_i} < h_q);

  // Grid edges and mirrored coordinates
  assign wm1      = w_q - DIM_BITS'(1);
  assign hm1      = h_q - DIM_BITS'(1);
  assign mir_x    = wm1 - {1'b0, x_q};
  assign mir_y    = hm1 - {1'b0, y_q};
  assign row_end  = ({1'b0, x_q} == wm1);
  assign last_row = ({1'b0, y_q} == hm1);
  assign col_end  = row_end && last_row;

  // Shift source, unwrapped and bounds-checked
  assign ox_raw = $signed({3'b000, x_q}) - $signed({sx_q[7], sx_q});
  assign oy_raw = $signed({3'b000, y_q}) - $signed({sy_q[7], sy_q});
  assign ok_x   = wrapx_q || (!ox_raw[8] && ({1'b0, ox_raw[7:0]} < {2'b00, w_q}));
  assign ok_y   = wrapy_q || (!oy_raw[8] && ({1'b0, oy_raw[7:0]} < {2'b00, h_q}));

  // Remainder step for the wrapped shift origin
  assign dx      = REM_BITS'({{DIM_BITS{1'b0}}, w_q} << k_q);
  assign dy      = REM_BITS'({{DIM_BITS{1'b0}}, h_q} << k_q);
  assign rx_step = (rx_q >= dx) ? (rx_q - dx) : rx_q;
  assign ry_step = (ry_q >= dy) ? (ry_q - dy) : ry_q;

  // Pick source and destination of the current scan cell
  always_comb begin
    src_x    = x_q;
    src_y    = y_q;
    src_ok   = 1'b1;
    dst_addr = {y_q, x_q};
    unique case (kind_q)
      XF_FLIP_H: begin
        src_x = mir_x[SIDE_BITS-1:0];
      end
      XF_FLIP_V: begin
        src_y = mir_y[SIDE_BITS-1:0];
      end
      XF_ROT_R: begin
        dst_addr = {x_q, mir_y[SIDE_BITS-1:0]};
      end
      XF_ROT_L: begin
        dst_addr = {mir_x[SIDE_BITS-1:0], y_q};
      end
      default: begin
        src_x  = wrapx_q ? oxw_q : ox_raw[SIDE_BITS-1:0];
        src_y  = wrapy_q ? oyw_q : oy_raw[SIDE_BITS-1:0];
        src_ok = ok_x && ok_y;
      end
    endcase
  end

  // Modify the cell read last cycle
  assign rd_flags = mem_rdata[FLAG_BITS-1:0];
  always_comb begin
    unique case (kind_q)
      XF_FLIP_H: new_flags = rd_flags ^ FLAG_H;
      XF_FLIP_V: new_flags = rd_flags ^ FLAG_V;
      XF_ROT_R:  new_flags = ROT_RIGHT_MAP[rd_flags];
      XF_ROT_L:  new_flags = ROT_LEFT_MAP[rd_flags];
      default:   new_flags = rd_flags;
    endcase
  end
  assign scan_wdata = wr_zero_q ? '0 : {mem_rdata[CELL_BITS-1:FLAG_BITS], new_flags};

  // Sequencer
  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    w_d          = w_q;
    h_d          = h_q;
    wr_pend_d    = 1'b0;
    x_d          = x_q;
    y_d          = y_q;
    kind_d       = kind_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    wrapx_d      = wrapx_q;
    wrapy_d      = wrapy_q;
    rx_d         = rx_q;
    ry_d         = ry_q;
    k_d          = k_q;
    ox0_d        = ox0_q;
    oxw_d        = oxw_q;
    oyw_d        = oyw_q;
    wr_addr_d    = wr_addr_q;
    wr_zero_d    = wr_zero_q;
    res_tile_d   = res_tile_q;
    res_flips_d  = res_flips_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;

    mem_req       = '0;
    mem_req.rbank = active_q;

    // Retire the scan write issued last cycle into the inactive bank
    if (wr_pend_q) begin
      mem_req.we    = 1'b1;
      mem_req.wbank = !active_q;
      mem_req.waddr = wr_addr_q;
      mem_req.wdata = scan_wdata;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_tile_d   = '0;
          res_flips_d  = '0;
          res_status_d = ST_OK;
          x_d          = '0;
          y_d          = '0;
          state_d      = S_DONE;
          unique case (req_type_i)
            REQ_NEW: begin
              if (new_width_i > DIM_BITS'(MAX_SIDE) || new_height_i > DIM_BITS'(MAX_SIDE)) begin
                res_status_d = ST_SIZE;
              end else begin
                w_d = new_width_i;
                h_d = new_height_i;
                if (new_width_i != '0 && new_height_i != '0) begin
                  state_d = S_CLEAR;
                end
              end
            end
            REQ_WRITE: begin
              if (!pos_in) begin
                res_status_d = ST_POS;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.wbank = active_q;
                mem_req.waddr = {pos_y_i, pos_x_i};
                mem_req.wdata = {tile_id_i, flip_bits_i};
              end
            end
            REQ_READ: begin
              if (!pos_in) begin
                res_status_d = ST_POS;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = {pos_y_i, pos_x_i};
                state_d       = S_RDATA;
              end
            end
            default: begin
              kind_d = transform_kind_i;
              if (transform_kind_i <= XF_SHIFT) begin
                sx_d    = shift_x_i;
                sy_d    = shift_y_i;
                wrapx_d = wrap_x_i;
                wrapy_d = wrap_y_i;
                // 127*side - shift is non-negative and below 256*side for side >= 1
                rx_d    = REM_BITS'(({{DIM_BITS{1'b0}}, w_q} << 7) - {{DIM_BITS{1'b0}}, w_q}
                          - {{(REM_BITS-8){shift_x_i[7]}}, shift_x_i});
                ry_d    = REM_BITS'(({{DIM_BITS{1'b0}}, h_q} << 7) - {{DIM_BITS{1'b0}}, h_q}
                          - {{(REM_BITS-8){shift_y_i[7]}}, shift_y_i});
                k_d     = 3'd7;
                state_d = S_SETUP;
              end
            end
          endcase
        end
      end

      S_CLEAR: begin
        // Zero one cell of the active bank per cycle
        mem_req.we    = 1'b1;
        mem_req.wbank = active_q;
        mem_req.waddr = {y_q, x_q};
        mem_req.wdata = '0;
        if (row_end) begin
          x_d = '0;
          y_d = y_q + SIDE_BITS'(1);
          if (last_row) begin
            state_d = S_DONE;
          end
        end else begin
          x_d = x_q + SIDE_BITS'(1);
        end
      end

      S_RDATA: begin
        res_tile_d  = mem_rdata[CELL_BITS-1:FLAG_BITS];
        res_flips_d = mem_rdata[FLAG_BITS-1:0];
        state_d     = S_DONE;
      end

      S_SETUP: begin
        // Reduce the shift origin modulo width and height
        rx_d = rx_step;
        ry_d = ry_step;
        k_d  = k_q - 3'd1;
        if (k_q == 3'd0) begin
          ox0_d = rx_step[SIDE_BITS-1:0];
          oxw_d = rx_step[SIDE_BITS-1:0];
          oyw_d = ry_step[SIDE_BITS-1:0];
          if (w_q == '0 || h_q == '0) begin
            active_d = !active_q;
            if (kind_q == XF_ROT_R || kind_q == XF_ROT_L) begin
              w_d = h_q;
              h_d = w_q;
            end
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Read one source cell, write it into the other bank next cycle
        mem_req.re    = src_ok;
        mem_req.raddr = {src_y, src_x};
        wr_pend_d     = 1'b1;
        wr_addr_d     = dst_addr;
        wr_zero_d     = !src_ok;
        if (row_end) begin
          x_d   = '0;
          y_d   = y_q + SIDE_BITS'(1);
          oxw_d = ox0_q;
          oyw_d = ({1'b0, oyw_q} == hm1) ? '0 : oyw_q + SIDE_BITS'(1);
        end else begin
          x_d   = x_q + SIDE_BITS'(1);
          oxw_d = ({1'b0, oxw_q} == wm1) ? '0 : oxw_q + SIDE_BITS'(1);
        end
        if (col_end) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        // Last write retires this cycle; swap banks
        active_d = !active_q;
        if (kind_q == XF_ROT_R || kind_q == XF_ROT_L) begin
          w_d = h_q;
          h_d = w_q;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output beat handshake
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      w_q         <= '0;
      h_q         <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      w_q         <= w_d;
      h_q         <= h_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    y_q          <= y_d;
    kind_q       <= kind_d;
    sx_q         <= sx_d;
    sy_q         <= sy_d;
    wrapx_q      <= wrapx_d;
    wrapy_q      <= wrapy_d;
    rx_q         <= rx_d;
    ry_q         <= ry_d;
    k_q          <= k_d;
    ox0_q        <= ox0_d;
    oxw_q        <= oxw_d;
    oyw_q        <= oyw_d;
    wr_addr_q    <= wr_addr_d;
    wr_zero_q    <= wr_zero_d;
    res_tile_q   <= res_tile_d;
    res_flips_q  <= res_flips_d;
    res_status_q <= res_status_d;
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_tile_q   <= res_tile_q;
      out_flips_q  <= res_flips_q;
      out_w_q      <= w_q;
      out_h_q      <= h_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_tile_o   = out_tile_q;
  assign cell_flips_o  = out_flips_q;
  assign grid_width_o  = out_w_q;
  assign grid_height_o = out_h_q;
  assign status_o      = out_status_q;

  // Scan writes only in flight while a transform walks the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q == S_SCAN || state_q == S_DRAIN))
    else $error("scan write pending outside transform");

  // Walk counters stay inside the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR || state_q == S_SCAN) |->
      ({1'b0, x_q} < w_q && {1'b0, y_q} < h_q))
    else $error("walk position outside grid");

  // Grid never grows beyond the largest side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_q <= DIM_BITS'(MAX_SIDE)) && (h_q <= DIM_BITS'(MAX_SIDE)))
    else $error("grid size above limit");

  // A finished transform swaps the active bank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAIN |=> active_q != $past(active_q))
    else $error("bank not swapped after transform");

endmodule

FILE: tb/tile_grid_flip_rotate_shift_test.sv
// Self-checking testbench for the tile grid block: new grid, cell access, flip/rotate/shift.
module tile_grid_flip_rotate_shift_test import tgfrs_pkg::*;;

  // One request beat and one result beat
  typedef struct packed {
    logic [1:0]           req_type;
    logic [5:0]           pos_x;
    logic [5:0]           pos_y;
    logic [TILE_BITS-1:0] tile_id;
    logic [2:0]           flip_bits;
    logic [2:0]           transform_kind;
    logic [7:0]           shift_x;
    logic [7:0]           shift_y;
    logic                 wrap_x;
    logic                 wrap_y;
    logic [6:0]           new_width;
    logic [6:0]           new_height;
  } tile_req_t;

  typedef struct packed {
    logic [TILE_BITS-1:0] tile;
    logic [2:0]           flips;
    logic [6:0]           width;
    logic [6:0]           height;
    logic [1:0]           status;
  } grid_resp_t;

  // Flag remap for a quarter turn clockwise and counterclockwise
  localparam logic [2:0] TURN_CW_FLAGS [8] = '{3'd5, 3'd4, 3'd1, 3'd0, 3'd7, 3'd6, 3'd3, 3'd2};
  localparam logic [2:0] TURN_CCW_FLAGS [8] = '{3'd3, 3'd2, 3'd7, 3'd6, 3'd1, 3'd0, 3'd5, 3'd4};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           req_type_i = '0;
  logic [5:0]           pos_x_i = '0;
  logic [5:0]           pos_y_i = '0;
  logic [TILE_BITS-1:0] tile_id_i = '0;
  logic [2:0]           flip_bits_i = '0;
  logic [2:0]           transform_kind_i = '0;
  logic [7:0]           shift_x_i = '0;
  logic [7:0]           shift_y_i = '0;
  logic                 wrap_x_i = 1'b0;
  logic                 wrap_y_i = 1'b0;
  logic [6:0]           new_width_i = '0;
  logic [6:0]           new_height_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [TILE_BITS-1:0] cell_tile_o;
  logic [2:0]           cell_flips_o;
  logic [6:0]           grid_width_o;
  logic [6:0]           grid_height_o;
  logic [1:0]           status_o;

  tile_grid_flip_rotate_shift u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .tile_id_i       (tile_id_i),
    .flip_bits_i     (flip_bits_i),
    .transform_kind_i(transform_kind_i),
    .shift_x_i       (shift_x_i),
    .shift_y_i       (shift_y_i),
    .wrap_x_i        (wrap_x_i),
    .wrap_y_i        (wrap_y_i),
    .new_width_i     (new_width_i),
    .new_height_i    (new_height_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cell_tile_o     (cell_tile_o),
    .cell_flips_o    (cell_flips_o),
    .grid_width_o    (grid_width_o),
    .grid_height_o   (grid_height_o),
    .status_o        (status_o)
  );

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow grid: two cell banks, live bank and size
  logic [CELL_BITS-1:0] grid_bank [2][DEPTH];
  logic live_bank;
  int live_w;
  int live_h;

  // Stimulus bookkeeping
  tile_req_t  pending_reqs [$];
  grid_resp_t expected_resps [$];
  tile_req_t  offered_req;
  int plan_w;
  int plan_h;
  int total_reqs = 0;
  int beats_in = 0;
  int beats_out = 0;
  int fail_count = 0;
  logic hold_ready = 1'b0;

  // Flat cell address of a grid position
  function automatic logic [ADDR_BITS-1:0] cell_addr(int x, int y);
    return ADDR_BITS'(y * MAX_SIDE + x);
  endfunction

  // Apply one request to the shadow grid and return the result it gives
  function automatic grid_resp_t apply_request(tile_req_t r);
    grid_resp_t rsp;
    logic [CELL_BITS-1:0] c;
    logic src, dst;
    int w, h, x, y, ox, oy, sx, sy, i;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.req_type)
      REQ_NEW: begin
        if (r.new_width > MAX_SIDE || r.new_height > MAX_SIDE) begin
          rsp.status = ST_SIZE;
        end else begin
          for (i = 0; i < DEPTH; i++) grid_bank[live_bank][ADDR_BITS'(i)] = '0;
          live_w = r.new_width;
          live_h = r.new_height;
        end
      end
      REQ_WRITE, REQ_READ: begin
        if (r.pos_x >= live_w || r.pos_y >= live_h) begin
          rsp.status = ST_POS;
        end else if (r.req_type == REQ_WRITE) begin
          grid_bank[live_bank][cell_addr(r.pos_x, r.pos_y)] = {r.tile_id, r.flip_bits};
        end else begin
          c = grid_bank[live_bank][cell_addr(r.pos_x, r.pos_y)];
          rsp.tile = c[CELL_BITS-1:FLAG_BITS];
          rsp.flips = c[FLAG_BITS-1:0];
        end
      end
      default: begin
        // Build the new grid in the idle bank, then swap
        if (r.transform_kind <= XF_SHIFT) begin
          src = live_bank;
          dst = !live_bank;
          w = live_w;
          h = live_h;
          sx = $signed(r.shift_x);
          sy = $signed(r.shift_y);
          for (i = 0; i < DEPTH; i++) grid_bank[dst][ADDR_BITS'(i)] = '0;
          for (y = 0; y < h; y++) begin
            for (x = 0; x < w; x++) begin
              c = grid_bank[src][cell_addr(x, y)];
              case (r.transform_kind)
                XF_FLIP_H: grid_bank[dst][cell_addr(x, y)] =
                             grid_bank[src][cell_addr(w - 1 - x, y)] ^ CELL_BITS'(FLAG_H);
                XF_FLIP_V: grid_bank[dst][cell_addr(x, y)] =
                             grid_bank[src][cell_addr(x, h - 1 - y)] ^ CELL_BITS'(FLAG_V);
                XF_ROT_R: grid_bank[dst][cell_addr(h - 1 - y, x)] =
                            {c[CELL_BITS-1:FLAG_BITS], TURN_CW_FLAGS[c[2:0]]};
                XF_ROT_L: grid_bank[dst][cell_addr(y, w - 1 - x)] =
                            {c[CELL_BITS-1:FLAG_BITS], TURN_CCW_FLAGS[c[2:0]]};
                default: begin
                  // Shift: pull from the displaced source, wrapping per axis
                  ox = x - sx;
                  oy = y - sy;
                  if (r.wrap_x && w > 0) begin
                    ox = ox % w;
                    if (ox < 0) ox += w;
                  end
                  if (r.wrap_y && h > 0) begin
                    oy = oy % h;
                    if (oy < 0) oy += h;
                  end
                  if (ox >= 0 && oy >= 0 && ox < w && oy < h)
                    grid_bank[dst][cell_addr(x, y)] = grid_bank[src][cell_addr(ox, oy)];
                end
              endcase
            end
          end
          if (r.transform_kind == XF_ROT_R || r.transform_kind == XF_ROT_L) begin
            live_w = h;
            live_h = w;
          end
          live_bank = dst;
        end
      end
    endcase
    rsp.width = 7'(live_w);
    rsp.height = 7'(live_h);
    return rsp;
  endfunction

  // Request with every field random; shifts lie in -64..64, the rest span their range
  function automatic tile_req_t blank_req();
    tile_req_t r;
    r.req_type = 2'($urandom_range(3));
    r.pos_x = 6'($urandom_range(63));
    r.pos_y = 6'($urandom_range(63));
    r.tile_id = TILE_BITS'($urandom_range(16'hFFFF));
    r.flip_bits = 3'($urandom_range(7));
    r.transform_kind = 3'($urandom_range(7));
    r.shift_x = 8'($urandom_range(128) - 64);
    r.shift_y = 8'($urandom_range(128) - 64);
    r.wrap_x = 1'($urandom_range(1));
    r.wrap_y = 1'($urandom_range(1));
    r.new_width = 7'($urandom_range(127));
    r.new_height = 7'($urandom_range(127));
    return r;
  endfunction

  // Queue a request and track the grid size it leaves
  function automatic void queue_req(tile_req_t r);
    int t;
    if (r.req_type == REQ_NEW && r.new_width <= MAX_SIDE && r.new_height <= MAX_SIDE) begin
      plan_w = r.new_width;
      plan_h = r.new_height;
    end
    if (r.req_type == REQ_XFORM &&
        (r.transform_kind == XF_ROT_R || r.transform_kind == XF_ROT_L)) begin
      t = plan_w;
      plan_w = plan_h;
      plan_h = t;
    end
    pending_reqs.push_back(r);
  endfunction

  function automatic void add_new_grid(int w, int h);
    tile_req_t r;
    r = blank_req();
    r.req_type = REQ_NEW;
    r.new_width = 7'(w);
    r.new_height = 7'(h);
    queue_req(r);
  endfunction

  function automatic void add_cell(logic [1:0] op, int x, int y, int tile, int flips);
    tile_req_t r;
    r = blank_req();
    r.req_type = op;
    r.pos_x = 6'(x);
    r.pos_y = 6'(y);
    r.tile_id = TILE_BITS'(tile);
    r.flip_bits = 3'(flips);
    queue_req(r);
  endfunction

  function automatic void add_xform(logic [2:0] kind, int sx, int sy, int wx, int wy);
    tile_req_t r;
    r = blank_req();
    r.req_type = REQ_XFORM;
    r.transform_kind = kind;
    r.shift_x = 8'(sx);
    r.shift_y = 8'(sy);
    r.wrap_x = 1'(wx);
    r.wrap_y = 1'(wy);
    queue_req(r);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Driver: offer queued beats, predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin : feed_p
    tile_req_t nxt;
    int idle_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_resps.push_back(apply_request(offered_req));
        beats_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        case (beats_in * 3 / total_reqs)
          0:       idle_pct = 38;
          1:       idle_pct = 73;
          default: idle_pct = 0;
        endcase
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_reqs.pop_front();
          offered_req      <= nxt;
          in_valid_i       <= 1'b1;
          req_type_i       <= nxt.req_type;
          pos_x_i          <= nxt.pos_x;
          pos_y_i          <= nxt.pos_y;
          tile_id_i        <= nxt.tile_id;
          flip_bits_i      <= nxt.flip_bits;
          transform_kind_i <= nxt.transform_kind;
          shift_x_i        <= nxt.shift_x;
          shift_y_i        <= nxt.shift_y;
          wrap_x_i         <= nxt.wrap_x;
          wrap_y_i         <= nxt.wrap_y;
          new_width_i      <= nxt.new_width;
          new_height_i     <= nxt.new_height;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, or hold off entirely while pressure is on
  always @(posedge clk_i or negedge rst_ni) begin : drain_p
    int idle_pct;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      case (beats_in * 3 / total_reqs)
        0:       idle_pct = 73;
        1:       idle_pct = 38;
        default: idle_pct = 0;
      endcase
      out_ready_i <= !hold_ready && ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : watch_p
    grid_resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_resps.size() == 0) begin
        $error("result beat with no request pending");
        fail_count++;
      end else begin
        want = expected_resps.pop_front();
        check_field("cell_tile", want.tile, cell_tile_o);
        check_field("cell_flips", want.flips, cell_flips_o);
        check_field("grid_width", want.width, grid_width_o);
        check_field("grid_height", want.height, grid_height_o);
        check_field("status", want.status, status_o);
        beats_out++;
      end
    end
  end

  // Long receiver hold-off so the block fills and stalls its input
  initial begin : squeeze_p
    int n;
    wait (total_reqs > 0 && beats_in >= (total_reqs * 3) / 4);
    @(posedge clk_i);
    hold_ready <= 1'b1;
    for (n = 0; n < 400; n++) @(posedge clk_i);
    hold_ready <= 1'b0;
  end

  // Run limit
  initial begin : limit_p
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : run_p
    int i, w, h, pick, n_ops, k, big_left, xf_left, x, y, sx, sy;
    logic [1:0] op;
    for (i = 0; i < DEPTH; i++) begin
      grid_bank[0][ADDR_BITS'(i)] = '0;
      grid_bank[1][ADDR_BITS'(i)] = '0;
    end
    live_bank = 1'b0;
    live_w = 0;
    live_h = 0;
    plan_w = 0;
    plan_h = 0;

    // Directed: empty grid, oversize, full size corners, rotations, shifts, odd kinds
    add_cell(REQ_READ, 0, 0, 0, 0);
    add_cell(REQ_WRITE, 5, 5, 16'hFFFF, 7);
    add_xform(XF_FLIP_H, 0, 0, 0, 0);
    add_new_grid(65, 10);
    add_new_grid(10, 127);
    add_new_grid(64, 64);
    add_cell(REQ_WRITE, 63, 63, 16'hFFFF, 7);
    add_cell(REQ_WRITE, 0, 0, 1, 0);
    add_cell(REQ_WRITE, 63, 0, 16'h8000, 5);
    add_cell(REQ_READ, 63, 63, 0, 0);
    add_xform(XF_FLIP_H, 0, 0, 0, 0);
    add_cell(REQ_READ, 0, 63, 0, 0);
    add_new_grid(3, 5);
    add_cell(REQ_WRITE, 2, 4, 16'h1234, 3);
    add_cell(REQ_WRITE, 0, 1, 16'hABCD, 6);
    add_xform(XF_ROT_R, 0, 0, 0, 0);
    add_cell(REQ_READ, 0, 2, 0, 0);
    add_xform(XF_ROT_L, 0, 0, 0, 0);
    add_xform(XF_FLIP_V, 0, 0, 0, 0);
    add_xform(XF_SHIFT, -64, 64, 1, 1);
    add_xform(XF_SHIFT, 1, -1, 0, 0);
    add_xform(3'd7, 0, 0, 0, 0);
    add_cell(REQ_READ, 3, 0, 0, 0);
    add_new_grid(0, 7);
    add_cell(REQ_WRITE, 0, 0, 16'h5555, 2);
    add_new_grid(64, 0);

    // Random: mostly a new grid followed by accesses and transforms on it
    big_left = 4;
    while (pending_reqs.size() < 1125) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        // oversize request, leaves the grid alone
        w = $urandom_range(65, 127);
        h = $urandom_range(127);
        if ($urandom_range(1)) add_new_grid(w, h);
        else add_new_grid(h, w);
      end else begin
        if (pick < 10 && big_left > 0) begin
          w = $urandom_range(9, 64);
          h = $urandom_range(9, 64);
          big_left--;
        end else if (pick < 16) begin
          w = $urandom_range(1) ? 0 : $urandom_range(8);
          h = (w == 0) ? $urandom_range(8) : 0;
        end else begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 8);
        end
        add_new_grid(w, h);
      end
      n_ops = $urandom_range(6, 24);
      xf_left = 3;
      for (k = 0; k < n_ops; k++) begin
        pick = $urandom_range(99);
        x = (plan_w > 0) ? $urandom_range(plan_w - 1) : $urandom_range(63);
        y = (plan_h > 0) ? $urandom_range(plan_h - 1) : $urandom_range(63);
        op = $urandom_range(1) ? REQ_WRITE : REQ_READ;
        if (pick < 10) begin
          // anywhere in the address space, often off the grid
          add_cell(op, $urandom_range(63), $urandom_range(63), $urandom_range(16'hFFFF),
                   $urandom_range(7));
        end else if (pick < 50) begin
          add_cell(REQ_WRITE, x, y, ($urandom_range(9) == 0) ? 0 : $urandom_range(16'hFFFF),
                   $urandom_range(7));
        end else if (pick < 80 || (plan_w * plan_h > 100 && xf_left == 0)) begin
          add_cell(REQ_READ, x, y, 0, 0);
        end else begin
          if (plan_w * plan_h > 100) xf_left--;
          if ($urandom_range(1)) begin
            sx = $urandom_range(128) - 64;
            sy = $urandom_range(128) - 64;
          end else begin
            sx = $urandom_range(8) - 4;
            sy = $urandom_range(8) - 4;
          end
          add_xform(3'(($urandom_range(19) == 0) ? $urandom_range(5, 7) : $urandom_range(4)),
                    sx, sy, $urandom_range(1), $urandom_range(1));
        end
      end
    end
    total_reqs = pending_reqs.size();

    // Reset, then wait for every result and a short drain
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (beats_out == total_reqs);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
